// ===== rtl/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants and types of the least-recently-used key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int EXT_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    typedef struct packed {
        logic             look;
        logic [KEY_W-1:0] key;
    } lkv_cell_ctrl_t;

endpackage

// ===== rtl/lkv_cell.sv =====
// ----------------------------------------------------------------------------
// lkv_cell
// One storage cell of the recency chain: holds a key, a value and a valid
// flag, compares its key with the request and takes its neighbour's entry
// when the chain shifts.
// ----------------------------------------------------------------------------
module lkv_cell
    import lkv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lkv_cell_ctrl_t    ctrl,
    input  logic              shift_en,
    input  logic [KEY_W-1:0]  prev_key,
    input  logic [VAL_W-1:0]  prev_value,
    input  logic              prev_valid,
    output logic [KEY_W-1:0]  key_o,
    output logic [VAL_W-1:0]  value_o,
    output logic              valid_o,
    output logic              match_o
);

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             valid_reg;
    logic             match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
        if (ctrl.look) begin
            match_reg <= valid_reg && (key_reg == ctrl.key);
        end
    end

    assign key_o   = key_reg;
    assign value_o = value_reg;
    assign valid_o = valid_reg;
    assign match_o = match_reg;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// A request is taken in ST_IDLE, compared in ST_LOOK and answered in ST_UPD,
// where the result is registered once no earlier result is held downstream.
// A new request is taken only back in ST_IDLE, after the compare and shift
// passes over the cell chain and any wait for the downstream side.
// Reset: synchronous active-low aresetn empties the cache and sets capacity 16.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// Entries sit in a chain of cells ordered by recency, the most recent first.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lkv_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [KEY_W+VAL_W-1:0]   s_tdata,   // lookup_key, write_value
    input  logic [0:0]               s_tuser,   // command
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [VAL_W-1:0]         m_tdata,   // read_value
    output logic [0:0]               m_tuser,   // hit
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } state_t;

    state_t           state_reg;
    logic             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] wval_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CAP_W-1:0] capacity_reg;
    logic             m_tvalid_reg;
    logic [VAL_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    logic [KEY_W-1:0] cell_key   [MAX_ENTRIES];
    logic [VAL_W-1:0] cell_value [MAX_ENTRIES];
    logic             cell_valid [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] shift_en;

    lkv_cell_ctrl_t   cell_ctrl;
    logic             upd_go;
    logic             hit;
    logic [VAL_W-1:0] hit_value;
    logic [VAL_W-1:0] new_value;
    logic [VAL_W-1:0] result_value;
    logic [EXT_W-1:0] cap_ext;
    logic [EXT_W-1:0] eff_cap;
    logic             full;
    logic [CNT_W-1:0] ins_pos;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? 32'(capacity_reg) : 32'd0;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign upd_go = (state_reg == ST_UPD) && (!m_tvalid_reg || m_tready);

    assign cell_ctrl.look = (state_reg == ST_LOOK);
    assign cell_ctrl.key  = key_reg;

    always_comb begin
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match[i]) begin
                hit_value = hit_value | cell_value[i];
            end
        end
    end

    assign hit = |match;

    always_comb begin
        cap_ext = EXT_W'(capacity_reg);
        if (cap_ext == '0) begin
            eff_cap = EXT_W'(1);
        end else if (cap_ext > EXT_W'(MAX_ENTRIES)) begin
            eff_cap = EXT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign full    = (EXT_W'(count_reg) >= eff_cap);
    assign ins_pos = full ? (count_reg - CNT_W'(1)) : count_reg;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit) begin
                shift_en[i] = upd_go && (|(match & ~((MAX_ENTRIES'(1) << i)
                                                      - MAX_ENTRIES'(1))));
            end else if (cmd_reg == CMD_PUT) begin
                shift_en[i] = upd_go && (CNT_W'(i) <= ins_pos);
            end else begin
                shift_en[i] = 1'b0;
            end
        end
    end

    assign new_value    = (cmd_reg == CMD_PUT) ? wval_reg : hit_value;
    assign result_value = (cmd_reg == CMD_PUT) ? '0 : (hit ? hit_value : MISS_VALUE);
    assign count_next   = ((cmd_reg == CMD_PUT) && !hit && !full)
                          ? (count_reg + CNT_W'(1)) : count_reg;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            lkv_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl),
                .shift_en   (shift_en[g]),
                .prev_key   (key_reg),
                .prev_value (new_value),
                .prev_valid (1'b1),
                .key_o      (cell_key[g]),
                .value_o    (cell_value[g]),
                .valid_o    (cell_valid[g]),
                .match_o    (match[g])
            );
        end else begin : g_body
            lkv_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl),
                .shift_en   (shift_en[g]),
                .prev_key   (cell_key[g-1]),
                .prev_value (cell_value[g-1]),
                .prev_valid (cell_valid[g-1]),
                .key_o      (cell_key[g]),
                .value_o    (cell_value[g]),
                .valid_o    (cell_valid[g]),
                .match_o    (match[g])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (upd_go) begin
                        state_reg    <= ST_IDLE;
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
        if ((state_reg == ST_IDLE) && s_tvalid) begin
            cmd_reg  <= s_tuser[0];
            key_reg  <= s_tdata[KEY_W-1:0];
            wval_reg <= s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        if (upd_go) begin
            m_tdata_reg <= result_value;
            m_tuser_reg <= hit;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds the number of cells");

    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> $onehot0(match))
        else $error("request key matches more than one cell");

    a_result_after_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_UPD))
        else $error("result raised outside the update pass");

    a_accept_to_look: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_LOOK))
        else $error("accepted request did not start a compare pass");
`endif

endmodule

// ===== tb/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking testbench for the least-recently-used key-value cache. A
// short table of directed requests covers key and value extremes, hits,
// misses, in-place updates and eviction. Random phases follow, one for each
// capacity setting, including zero, saturating and lowered capacities. A
// cycle-accurate-free predictor keeps its own copy of the cache and ranks,
// and every response is compared in order against it or a table row's result,
// with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
    import lkv_pkg::*;

    localparam logic [2:0] ADDR_CAPACITY = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_REQUESTS = 250;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } cache_result_t;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             typed;
        cache_result_t    result;
    } directed_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [KEY_W+VAL_W-1:0] s_tdata = '0;   // lookup_key, write_value
    logic [0:0]             s_tuser = '0;   // command
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [VAL_W-1:0]       m_tdata;        // read_value
    logic [0:0]             m_tuser;        // hit
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    lru_key_value_cache DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    logic [KEY_W-1:0] cache_keys [MAX_ENTRIES];
    logic [VAL_W-1:0] cache_vals [MAX_ENTRIES];
    bit               cache_valid [MAX_ENTRIES];
    int unsigned      cache_rank [MAX_ENTRIES];
    int unsigned      cache_count = 0;
    logic [CAP_W-1:0] capacity_reg = CAPACITY_RESET;

    cache_result_t    expected_results [$];
    directed_row_t    directed_rows [$];
    int               mismatches = 0;
    int               idle_cycles = 0;
    bit               calm = 1'b0;
    int               stall_left = 0;

    // Every valid entry more recent than the given slot ages by one.
    function automatic void promote(int s);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (cache_valid[i] && i != s && cache_rank[i] < cache_rank[s]) begin
                cache_rank[i]++;
            end
        end
        cache_rank[s] = 0;
    endfunction

    function automatic cache_result_t cache_access(logic cmd, logic [KEY_W-1:0] key,
                                                   logic [VAL_W-1:0] value);
        cache_result_t res;
        int            slot;
        int            limit;
        bit            found;
        found = 1'b0;
        slot  = -1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (!found && cache_valid[i] && cache_keys[i] == key) begin
                slot  = i;
                found = 1'b1;
            end
        end
        res.hit = found;
        if (cmd == CMD_GET) begin
            res.value = found ? cache_vals[slot] : MISS_VALUE;
            if (found) begin
                promote(slot);
            end
            return res;
        end
        res.value = '0;
        if (found) begin
            cache_vals[slot] = value;
            promote(slot);
            return res;
        end
        limit = (capacity_reg == 0) ? 1 :
                (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_reg);
        if (cache_count >= limit) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (cache_valid[i] && (slot < 0 || cache_rank[i] > cache_rank[slot])) begin
                    slot = i;
                end
            end
            cache_keys[slot] = key;
            cache_vals[slot] = value;
            promote(slot);
            return res;
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (slot < 0 && !cache_valid[i]) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (cache_valid[i]) begin
                    cache_rank[i]++;
                end
            end
            cache_valid[slot] = 1'b1;
            cache_keys[slot]  = key;
            cache_vals[slot]  = value;
            cache_rank[slot]  = 0;
            cache_count++;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                                bit typed, cache_result_t typed_result);
        cache_result_t predicted;
        int            gap;
        s_tdata  <= {value, key};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        predicted = cache_access(cmd, key, value);
        expected_results.push_back(typed ? typed_result : predicted);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CAPACITY) begin
            capacity_reg = data[CAP_W-1:0];
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, cache_result_t exp_res, cache_result_t act_res);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected hit=%0b value=%h, got hit=%0b value=%h",
                     $realtime, what, exp_res.hit, exp_res.value, act_res.hit, act_res.value);
        end
    endtask

    // Receiver side: random stalls, with calm stretches where it starts no new stall.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cache_result_t observed;
        cache_result_t oldest;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                observed.hit   = m_tuser[0];
                observed.value = m_tdata;
                if (expected_results.size() == 0) begin
                    report_mismatch("response with no request outstanding", '0, observed);
                end else begin
                    oldest = expected_results.pop_front();
                    if (observed !== oldest) begin
                        report_mismatch("response mismatch", oldest, observed);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int               cap_plan [8];
        logic [KEY_W-1:0] key_pool [$];
        logic [KEY_W-1:0] key;
        int               pool_size;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            cache_valid[i] = 1'b0;
            cache_rank[i]  = 0;
        end
        cap_plan = '{1, 0, 4, 31, 2, 17, 8, 16};

        directed_rows.push_back('{CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}});
        directed_rows.push_back('{CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0}});
        directed_rows.push_back('{CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF}});
        directed_rows.push_back('{CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 32'h0}});
        directed_rows.push_back('{CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h8000_0000}});
        directed_rows.push_back('{CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0}});
        directed_rows.push_back('{CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF}});
        directed_rows.push_back('{CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}});
        directed_rows.push_back('{CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0}});
        directed_rows.push_back('{CMD_GET, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, '{1'b1, 32'h0}});
        directed_rows.push_back('{CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, MISS_VALUE}});
        // Fourteen new keys fill the cache and push out its oldest entry.
        for (int i = 0; i < 14; i++) begin
            directed_rows.push_back('{CMD_PUT, 32'(100 + i), $urandom(), 1'b0, '0});
        end
        directed_rows.push_back('{CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}});

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].result);
        end

        foreach (cap_plan[p]) begin
            drain_results();
            if (p == 2) begin
                write_register(ADDR_UNMAPPED, $urandom());
            end
            write_register(ADDR_CAPACITY, {27'($urandom()), 5'(cap_plan[p])});
            pool_size = (cap_plan[p] == 0 ? 1 : cap_plan[p] > 16 ? 16 : cap_plan[p]) + 3;
            key_pool.delete();
            for (int i = 0; i < pool_size; i++) begin
                key_pool.push_back($urandom());
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n % 50 == 0) begin
                    calm <= ($urandom_range(0, 3) == 0);
                end
                if (p == 4 && n == PHASE_REQUESTS / 2) begin
                    drain_results();
                end
                key = ($urandom_range(0, 15) == 0) ? $urandom()
                                                   : key_pool[$urandom_range(0, pool_size - 1)];
                send_request($urandom_range(0, 1) ? CMD_PUT : CMD_GET, key, $urandom(),
                             1'b0, '0);
            end
        end
        drain_results();

        mismatches += expected_results.size();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== lru_key_value_cache.f =====
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache.sv
tb/tb_lru_key_value_cache.sv
